@@ hdl/fba_pkg.sv @@
// shared types, constants and codes of the fixed bucket allocator
package fba_pkg;

    // pool geometry
    localparam int MAX_BUCKETS = 1024;
    localparam int ID_W        = $clog2(MAX_BUCKETS);
    localparam int CNT_W       = ID_W + 1;

    // limit clamps and reset values
    localparam logic [16:0] VERTEX_LIMIT_HIGH = 17'd65536;
    localparam logic [18:0] INDEX_LIMIT_HIGH  = 19'd262144;
    localparam logic [10:0] BUCKET_COUNT_RST  = 11'd1024;
    localparam logic [16:0] VERTEX_LIMIT_RST  = 17'd16384;
    localparam logic [18:0] INDEX_LIMIT_RST   = 19'd65536;

    // configuration register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam int          CFG_DATA_W       = 19;
    localparam logic [1:0]  CFG_BUCKET_COUNT = 2'd0;
    localparam logic [1:0]  CFG_VERTEX_LIMIT = 2'd1;
    localparam logic [1:0]  CFG_INDEX_LIMIT  = 2'd2;

    // operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    // request transaction
    typedef struct packed {
        logic [1:0]  operation;
        logic [23:0] vertex_count;
        logic [23:0] index_count;
        logic [10:0] release_bucket;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  granted_bucket;
        logic [25:0] vertex_offset;
        logic [27:0] index_offset;
        logic [16:0] granted_vertices;
        logic [18:0] granted_indices;
        logic [10:0] buckets_in_use;
    } t_out_item;

    // free stack access
    typedef struct packed {
        logic            rd_en;
        logic [ID_W-1:0] rd_pos;
        logic            wr_en;
        logic [ID_W-1:0] wr_pos;
        logic [ID_W-1:0] wr_id;
    } t_stack_cmd;

    // use mark access
    typedef struct packed {
        logic            rd_en;
        logic [ID_W-1:0] rd_id;
        logic            wr_en;
        logic [ID_W-1:0] wr_id;
        logic            wr_mark;
    } t_mark_cmd;

endpackage

@@ hdl/fba_free_stack.sv @@
// free stack memory with low-water-mark resolution of never-written slots
module fba_free_stack
    import fba_pkg::*;
(
    input  logic             i_clk,
    input  t_stack_cmd       i_cmd,
    input  logic [CNT_W-1:0] i_pool,
    input  logic [CNT_W-1:0] i_low,
    output logic [ID_W-1:0]  o_top_id
);

    logic [ID_W-1:0]  r_mem [MAX_BUCKETS];
    logic [ID_W-1:0]  r_rd_data;
    logic [ID_W-1:0]  r_rd_pos;
    logic [CNT_W-1:0] w_init_id;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_pos] <= i_cmd.wr_id;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_pos];
            r_rd_pos  <= i_cmd.rd_pos;
        end
    end

    // slots below the low-water mark still hold their initial descending ids
    assign w_init_id = i_pool - CNT_W'(1) - {1'b0, r_rd_pos};
    assign o_top_id  = ({1'b0, r_rd_pos} < i_low) ? w_init_id[ID_W-1:0] : r_rd_data;

endmodule

@@ hdl/fba_use_marks.sv @@
// per-bucket in-use marks, valid only for ids handed out since the last rebuild
module fba_use_marks
    import fba_pkg::*;
(
    input  logic             i_clk,
    input  t_mark_cmd        i_cmd,
    input  logic [CNT_W-1:0] i_fresh_limit,
    output logic             o_in_use
);

    logic            r_mem [MAX_BUCKETS];
    logic            r_rd_data;
    logic [ID_W-1:0] r_rd_id;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_id] <= i_cmd.wr_mark;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_id];
            r_rd_id   <= i_cmd.rd_id;
        end
    end

    // ids at or above the fresh limit were never popped, so their mark is stale
    assign o_in_use = r_rd_data & ({1'b0, r_rd_id} < i_fresh_limit);

endmodule

@@ hdl/fixed_bucket_allocator.sv @@
// Fixed bucket allocator: hands out equal buckets from a last-in-first-out free list.
// A transaction is accepted in the idle state, which issues reads of the free stack memory
// and the use mark memory; the execute state then decides, writes both memories back and
// loads the result register, as both memories have a registered read. A new transaction
// is accepted while a result still waits to be taken, and the decide cycle holds only
// while that earlier result is still unclaimed. No clearing pass
// is needed after reset or reinitialize: a low-water mark on the stack depth tells which
// stack slots and which use marks were written since the pool was rebuilt.
module fixed_bucket_allocator
    import fba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state           r_state, n_state;
    t_in_item         r_req;
    logic [10:0]      r_bucket_count;
    logic [16:0]      r_vertex_limit;
    logic [18:0]      r_index_limit;
    logic [CNT_W-1:0] r_pool, n_pool;
    logic [CNT_W-1:0] r_depth, n_depth;
    logic [CNT_W-1:0] r_low, n_low;
    logic [CNT_W-1:0] r_used, n_used;
    logic             r_out_valid;
    t_out_item        r_out, n_out;

    logic             w_accept;
    logic             w_fire;
    logic [16:0]      w_vlim;
    logic [18:0]      w_ilim;
    logic [CNT_W-1:0] w_pool_cfg;
    logic             w_empty;
    logic             w_too_big;
    logic             w_alloc_ok;
    logic             w_free_ok;
    logic             w_in_use;
    logic [ID_W-1:0]  w_top_id;
    logic [CNT_W-1:0] w_depth_dec;
    logic [26:0]      w_vprod;
    logic [28:0]      w_iprod;
    t_stack_cmd       w_stack_cmd;
    t_mark_cmd        w_mark_cmd;

    // handshake
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_fire      = (r_state == S_EXEC) & (~r_out_valid | i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // clamped limits and pool size
    assign w_vlim     = (r_vertex_limit > VERTEX_LIMIT_HIGH) ? VERTEX_LIMIT_HIGH : r_vertex_limit;
    assign w_ilim     = (r_index_limit > INDEX_LIMIT_HIGH) ? INDEX_LIMIT_HIGH : r_index_limit;
    assign w_pool_cfg = (r_bucket_count > CNT_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS)
                                                               : r_bucket_count;

    // request decode
    assign w_depth_dec = r_depth - CNT_W'(1);
    assign w_empty     = (r_depth == '0);
    assign w_too_big   = (r_req.vertex_count > {7'd0, w_vlim})
                       | (r_req.index_count > {5'd0, w_ilim});
    assign w_alloc_ok  = (r_req.operation == OP_ALLOC) & ~w_empty & ~w_too_big;
    assign w_free_ok   = (r_req.operation == OP_FREE) & w_in_use
                       & (r_req.release_bucket < r_pool);

    // offsets of the popped bucket
    assign w_vprod = 27'({17'd0, w_top_id} * {10'd0, w_vlim});
    assign w_iprod = 29'({19'd0, w_top_id} * {10'd0, w_ilim});

    // memory commands
    always_comb begin
        w_stack_cmd.rd_en  = w_accept;
        w_stack_cmd.rd_pos = w_depth_dec[ID_W-1:0];
        w_stack_cmd.wr_en  = w_fire & w_free_ok;
        w_stack_cmd.wr_pos = r_depth[ID_W-1:0];
        w_stack_cmd.wr_id  = r_req.release_bucket[ID_W-1:0];

        w_mark_cmd.rd_en   = w_accept;
        w_mark_cmd.rd_id   = i_in_data.release_bucket[ID_W-1:0];
        w_mark_cmd.wr_en   = w_fire & (w_alloc_ok | w_free_ok);
        w_mark_cmd.wr_id   = w_alloc_ok ? w_top_id : r_req.release_bucket[ID_W-1:0];
        w_mark_cmd.wr_mark = w_alloc_ok;
    end

    fba_free_stack u_free_stack (
        .i_clk    (i_clk),
        .i_cmd    (w_stack_cmd),
        .i_pool   (r_pool),
        .i_low    (r_low),
        .o_top_id (w_top_id)
    );

    fba_use_marks u_use_marks (
        .i_clk         (i_clk),
        .i_cmd         (w_mark_cmd),
        .i_fresh_limit (r_pool - r_low),
        .o_in_use      (w_in_use)
    );

    // next pool state and result
    always_comb begin
        n_pool  = r_pool;
        n_depth = r_depth;
        n_low   = r_low;
        n_used  = r_used;
        n_out   = '0;
        unique case (r_req.operation)
            OP_ALLOC: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else if (w_too_big) begin
                    n_out.status = ST_TOO_BIG;
                end else begin
                    n_out.status           = ST_OK;
                    n_depth                = w_depth_dec;
                    n_low                  = (w_depth_dec < r_low) ? w_depth_dec : r_low;
                    n_used                 = r_used + CNT_W'(1);
                    n_out.granted_bucket   = w_top_id;
                    n_out.vertex_offset    = w_vprod[25:0];
                    n_out.index_offset     = w_iprod[27:0];
                    n_out.granted_vertices = r_req.vertex_count[16:0];
                    n_out.granted_indices  = r_req.index_count[18:0];
                end
            end
            OP_FREE: begin
                if (w_free_ok) begin
                    n_out.status = ST_OK;
                    n_depth      = r_depth + CNT_W'(1);
                    n_used       = r_used - CNT_W'(1);
                end else begin
                    n_out.status = ST_REJECTED;
                end
            end
            OP_REINIT: begin
                n_out.status = ST_OK;
                n_pool       = w_pool_cfg;
                n_depth      = w_pool_cfg;
                n_low        = w_pool_cfg;
                n_used       = '0;
            end
            default: begin
                n_out.status = ST_REJECTED;
            end
        endcase
        n_out.buckets_in_use = n_used;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bucket_count <= BUCKET_COUNT_RST;
            r_vertex_limit <= VERTEX_LIMIT_RST;
            r_index_limit  <= INDEX_LIMIT_RST;
            r_pool         <= CNT_W'(MAX_BUCKETS);
            r_depth        <= CNT_W'(MAX_BUCKETS);
            r_low          <= CNT_W'(MAX_BUCKETS);
            r_used         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BUCKET_COUNT: r_bucket_count <= i_cfg_data[10:0];
                    CFG_VERTEX_LIMIT: r_vertex_limit <= i_cfg_data[16:0];
                    CFG_INDEX_LIMIT:  r_index_limit  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_fire) begin
                r_pool      <= n_pool;
                r_depth     <= n_depth;
                r_low       <= n_low;
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule
